[rtl/tksd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_pkg: shared types and constants of the terminal key sequence decoder
// Key kinds, the classified byte that crosses from front to back, the result
// item, and the byte codes that both halves look at.
// ----------------------------------------------------------------------------
package tksd_pkg;

   // default depth of the internal queues
   localparam int TKSD_QUEUE_DEPTH = 2;

   // result key kinds
   typedef enum logic [3:0] {
      KK_CHAR      = 4'd0,
      KK_UNKNOWN   = 4'd1,
      KK_ESC       = 4'd2,
      KK_ENTER     = 4'd3,
      KK_BACKSPACE = 4'd4,
      KK_CTRLC     = 4'd5,
      KK_SPACE     = 4'd6,
      KK_UP        = 4'd7,
      KK_DOWN      = 4'd8,
      KK_RIGHT     = 4'd9,
      KK_LEFT      = 4'd10,
      KK_HOME      = 4'd11,
      KK_END       = 4'd12,
      KK_PGUP      = 4'd13,
      KK_PGDN      = 4'd14
   } key_kind_type;

   // escape sequence state
   typedef enum logic [1:0] {
      SEQ_NORMAL = 2'd0,
      SEQ_ESC    = 2'd1,
      SEQ_CSI    = 2'd2,
      SEQ_SS3    = 2'd3
   } seq_state_type;

   // first CSI parameter parse stage
   typedef enum logic [1:0] {
      PS_SKIP   = 2'd0,
      PS_SIGN   = 2'd1,
      PS_DIGITS = 2'd2,
      PS_DONE   = 2'd3
   } param_stage_type;

   // byte codes
   localparam logic [7:0] CH_ETX     = 8'h03;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_FINAL_HI = 8'h7E;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_UPPER_D = 8'h44;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_H = 8'h48;
   localparam logic [7:0] CH_UPPER_O = 8'h4F;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_TILDE   = 8'h7E;

   // classified input item, front to back
   typedef struct packed {
      logic       tick;
      logic [7:0] byte_value;
      logic       is_final;
      logic       is_digit;
      logic       is_space;
      logic       is_cont;
   } item_type;

   // result item
   typedef struct packed {
      key_kind_type key_kind;
      logic [20:0]  code_point;
   } rsp_type;

endpackage

[rtl/tksd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_fifo: small register queue
// Circular buffer with full and empty flags; push and pop may happen in the
// same cycle.
// ----------------------------------------------------------------------------
module tksd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = tksd_pkg::TKSD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import tksd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/tksd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_front: input side of the decoder
// Accepts ticks and bytes, tags each byte with its character classes and
// queues the tagged item for the back end.
// ----------------------------------------------------------------------------
module tksd_front #(
   parameter int QUEUE_DEPTH = tksd_pkg::TKSD_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic [7:0]         req_byte_value,
   output logic               item_valid,
   output tksd_pkg::item_type item,
   input  logic               item_pop
);
   import tksd_pkg::*;

   item_type                  item_wr;
   logic [$bits(item_type)-1:0] item_rd;
   logic                      item_empty;

   // character classes
   always_comb begin
      item_wr.tick       = req_mode;
      item_wr.byte_value = req_byte_value;
      item_wr.is_final   = (req_byte_value >= CH_FINAL_LO) && (req_byte_value <= CH_FINAL_HI);
      item_wr.is_digit   = (req_byte_value >= CH_ZERO) && (req_byte_value <= CH_NINE);
      item_wr.is_space   = (req_byte_value == CH_SPACE) ||
                           ((req_byte_value >= 8'h09) && (req_byte_value <= 8'h0D));
      item_wr.is_cont    = (req_byte_value[7:6] == 2'b10);
   end

   tksd_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (item_wr),
      .full    (req_full),
      .pop     (item_pop),
      .rd_data (item_rd),
      .empty   (item_empty)
   );

   assign item_valid = ~item_empty;
   assign item       = item_type'(item_rd);

endmodule

[rtl/tksd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_back: sequence and UTF-8 decoder
// Takes one classified item a cycle while the result queue is not full, advances
// the escape, CSI parameter and UTF-8 state, and produces at most one key event.
// ----------------------------------------------------------------------------
module tksd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  tksd_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_push,
   output tksd_pkg::rsp_type  rsp_data,
   input  logic               rsp_full
);
   import tksd_pkg::*;

   seq_state_type   seq_ff, seq_in;
   param_stage_type stage_ff, stage_in;
   logic [3:0]      value_ff, value_in;
   logic            neg_ff, neg_in;
   logic            nonempty_ff, nonempty_in;
   logic [1:0]      rem_ff, rem_in;
   logic [2:0]      len_ff, len_in;
   logic [20:0]     acc_ff, acc_in;
   logic            bad_ff, bad_in;

   logic [7:0]      b;
   logic [20:0]     acc_shift;
   logic            cont_bad;
   logic            fin_bad;
   logic [3:0]      param_eff;
   logic            has_rsp;
   key_kind_type    kind;
   logic [20:0]     cp;

   // letter finals shared by CSI and SS3
   function automatic key_kind_type letter_kind(input logic [7:0] c);
      key_kind_type k;
      case (c)
         CH_UPPER_A: k = KK_UP;
         CH_UPPER_B: k = KK_DOWN;
         CH_UPPER_C: k = KK_RIGHT;
         CH_UPPER_D: k = KK_LEFT;
         CH_UPPER_H: k = KK_HOME;
         CH_UPPER_F: k = KK_END;
         default:    k = KK_UNKNOWN;
      endcase
      return k;
   endfunction

   // ESC [ n ~ keys
   function automatic key_kind_type tilde_kind(input logic [3:0] p);
      key_kind_type k;
      case (p)
         4'd1, 4'd7: k = KK_HOME;
         4'd4, 4'd8: k = KK_END;
         4'd5:       k = KK_PGUP;
         4'd6:       k = KK_PGDN;
         default:    k = KK_UNKNOWN;
      endcase
      return k;
   endfunction

   assign b         = item.byte_value;
   assign item_pop  = item_valid & ~rsp_full;
   assign acc_shift = {acc_ff[14:0], b[5:0]};
   assign cont_bad  = bad_ff | ~item.is_cont;
   assign param_eff = nonempty_ff ? value_ff : 4'd1;

   // strict UTF-8 check on the completed code point
   assign fin_bad = cont_bad
      | ((len_ff == 3'd2) && (acc_shift < 21'h80))
      | ((len_ff == 3'd3) && ((acc_shift < 21'h800) ||
                              ((acc_shift >= 21'hD800) && (acc_shift <= 21'hDFFF))))
      | ((len_ff == 3'd4) && ((acc_shift < 21'h10000) || (acc_shift > 21'h10FFFF)));

   // next state and result
   always_comb begin
      seq_in      = seq_ff;
      stage_in    = stage_ff;
      value_in    = value_ff;
      neg_in      = neg_ff;
      nonempty_in = nonempty_ff;
      rem_in      = rem_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;
      has_rsp     = 1'b0;
      kind        = KK_UNKNOWN;
      cp          = '0;
      if (item_pop) begin
         if (item.tick) begin
            // flush a pending escape or a partial UTF-8 sequence
            if (seq_ff != SEQ_NORMAL) begin
               seq_in      = SEQ_NORMAL;
               stage_in    = PS_SKIP;
               value_in    = '0;
               neg_in      = 1'b0;
               nonempty_in = 1'b0;
               has_rsp     = 1'b1;
               kind        = KK_ESC;
            end else if (rem_ff != 2'd0) begin
               rem_in  = '0;
               len_in  = '0;
               acc_in  = '0;
               bad_in  = 1'b0;
               has_rsp = 1'b1;
               kind    = KK_UNKNOWN;
            end
         end else if (rem_ff != 2'd0) begin
            // continuation byte; any byte counts here
            rem_in = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               len_in  = '0;
               acc_in  = '0;
               bad_in  = 1'b0;
               has_rsp = 1'b1;
               if (fin_bad) begin
                  kind = KK_UNKNOWN;
               end else begin
                  kind = KK_CHAR;
                  cp   = acc_shift;
               end
            end else begin
               acc_in = acc_shift;
               bad_in = cont_bad;
            end
         end else begin
            case (seq_ff)
               SEQ_ESC: begin
                  seq_in      = SEQ_NORMAL;
                  stage_in    = PS_SKIP;
                  value_in    = '0;
                  neg_in      = 1'b0;
                  nonempty_in = 1'b0;
                  if (b == CH_LBRACK) begin
                     seq_in = SEQ_CSI;
                  end else if (b == CH_UPPER_O) begin
                     seq_in = SEQ_SS3;
                  end else begin
                     stage_in    = stage_ff;
                     value_in    = value_ff;
                     neg_in      = neg_ff;
                     nonempty_in = nonempty_ff;
                     has_rsp     = 1'b1;
                     kind        = KK_ESC;
                  end
               end
               SEQ_CSI: begin
                  if (item.is_final) begin
                     seq_in      = SEQ_NORMAL;
                     stage_in    = PS_SKIP;
                     value_in    = '0;
                     neg_in      = 1'b0;
                     nonempty_in = 1'b0;
                     has_rsp     = 1'b1;
                     if (b == CH_TILDE) begin
                        kind = (nonempty_ff && neg_ff) ? KK_UNKNOWN : tilde_kind(param_eff);
                     end else begin
                        kind = letter_kind(b);
                     end
                  end else if (stage_ff != PS_DONE) begin
                     // first parameter, read like atoi, saturating at nine
                     if (b == CH_SEMI) begin
                        stage_in = PS_DONE;
                     end else begin
                        nonempty_in = 1'b1;
                        if (stage_ff == PS_SKIP && item.is_space) begin
                           stage_in = PS_SKIP;
                        end else if (stage_ff == PS_SKIP && b == CH_PLUS) begin
                           stage_in = PS_SIGN;
                        end else if (stage_ff == PS_SKIP && b == CH_MINUS) begin
                           stage_in = PS_SIGN;
                           neg_in   = 1'b1;
                        end else if (item.is_digit) begin
                           value_in = (value_ff == 4'd0) ? b[3:0] : 4'd9;
                           stage_in = PS_DIGITS;
                        end else begin
                           stage_in = PS_DONE;
                        end
                     end
                  end
               end
               SEQ_SS3: begin
                  seq_in  = SEQ_NORMAL;
                  has_rsp = 1'b1;
                  kind    = item.is_final ? letter_kind(b) : KK_UNKNOWN;
               end
               default: begin
                  // plain bytes and UTF-8 lead bytes
                  has_rsp = 1'b1;
                  if (b == CH_ESC) begin
                     seq_in  = SEQ_ESC;
                     has_rsp = 1'b0;
                  end else if (b == CH_CR || b == CH_LF) begin
                     kind = KK_ENTER;
                  end else if (b == CH_DEL || b == CH_BS) begin
                     kind = KK_BACKSPACE;
                  end else if (b == CH_ETX) begin
                     kind = KK_CTRLC;
                  end else if (b == CH_SPACE) begin
                     kind = KK_SPACE;
                  end else if (b < 8'h20) begin
                     kind = KK_UNKNOWN;
                  end else if (b < 8'h80) begin
                     kind = KK_CHAR;
                     cp   = {13'd0, b};
                  end else if (b >= 8'hC2 && b <= 8'hDF) begin
                     has_rsp = 1'b0;
                     len_in  = 3'd2;
                     rem_in  = 2'd1;
                     acc_in  = {16'd0, b[4:0]};
                     bad_in  = 1'b0;
                  end else if (b >= 8'hE0 && b <= 8'hEF) begin
                     has_rsp = 1'b0;
                     len_in  = 3'd3;
                     rem_in  = 2'd2;
                     acc_in  = {17'd0, b[3:0]};
                     bad_in  = 1'b0;
                  end else if (b >= 8'hF0 && b <= 8'hF4) begin
                     has_rsp = 1'b0;
                     len_in  = 3'd4;
                     rem_in  = 2'd3;
                     acc_in  = {18'd0, b[2:0]};
                     bad_in  = 1'b0;
                  end else begin
                     kind = KK_UNKNOWN;
                  end
               end
            endcase
         end
      end
   end

   assign rsp_push            = item_pop & has_rsp;
   assign rsp_data.key_kind   = kind;
   assign rsp_data.code_point = cp;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= SEQ_NORMAL;
         stage_ff    <= PS_SKIP;
         value_ff    <= '0;
         neg_ff      <= 1'b0;
         nonempty_ff <= 1'b0;
         rem_ff      <= '0;
         len_ff      <= '0;
         acc_ff      <= '0;
         bad_ff      <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         stage_ff    <= stage_in;
         value_ff    <= value_in;
         neg_ff      <= neg_in;
         nonempty_ff <= nonempty_in;
         rem_ff      <= rem_in;
         len_ff      <= len_in;
         acc_ff      <= acc_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

[rtl/terminal_key_sequence_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder: terminal byte stream to key events
// Decodes control bytes, ESC [ ... and ESC O x sequences and UTF-8 into key
// events; a tick flushes an incomplete sequence.
// ----------------------------------------------------------------------------
// The decoder takes one byte or tick per cycle while req_full is low and gives
// at most one key event for it. A transfer on the req_ side passes through the
// classified-item queue, the back end and then the result queue on its way to
// the rsp_ side. The decode state advances once per cycle in the back end, so a
// byte every cycle is sustained as long as results are popped; both queues hold
// QUEUE_DEPTH items, and full rises only when the input queue is that deep.
module terminal_key_sequence_decoder #(
   parameter int QUEUE_DEPTH = tksd_pkg::TKSD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_key_kind,
   output logic [20:0] rsp_code_point
);
   import tksd_pkg::*;

   logic                       item_valid;
   item_type                   item;
   logic                       item_pop;
   logic                       rsp_push;
   rsp_type                    rsp_in;
   logic                       rsp_fifo_full;
   logic [$bits(rsp_type)-1:0] rsp_rd;
   rsp_type                    rsp_out;

   // input side: classify and queue
   tksd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   // decode state
   tksd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in),
      .rsp_full   (rsp_fifo_full)
   );

   // result queue
   tksd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_fifo_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_out        = rsp_type'(rsp_rd);
   assign rsp_key_kind   = rsp_out.key_kind;
   assign rsp_code_point = rsp_out.code_point;

   // checks
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_fifo_full)
      else $error("result written into a full result queue");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end consumed an item from an empty queue");

   a_cp_zero_unless_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_in.key_kind != KK_CHAR) |-> (rsp_in.code_point == 21'd0))
      else $error("non-character key event carries a code point");

endmodule

[tb/sv/tksd_key_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_key_event_checker: key event predictor and scoreboard
// Watches both queue ports of the decoder. Every accepted byte or tick is run
// through a local decode model; the key event it yields is queued and compared
// field by field against the next key event popped from the decoder.
// ----------------------------------------------------------------------------
module tksd_key_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_mode,
   input  logic [7:0]  req_byte_value,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [3:0]  rsp_key_kind,
   input  logic [20:0] rsp_code_point,
   output int          fail_count,
   output int          pending_count
);
   import tksd_pkg::*;

   // byte classes and code point limits
   localparam logic [7:0]  CH_TAB     = 8'h09;
   localparam logic [7:0]  ASCII_END  = 8'h80;
   localparam logic [7:0]  LEAD2_LO   = 8'hC2;
   localparam logic [7:0]  LEAD2_HI   = 8'hDF;
   localparam logic [7:0]  LEAD3_LO   = 8'hE0;
   localparam logic [7:0]  LEAD3_HI   = 8'hEF;
   localparam logic [7:0]  LEAD4_LO   = 8'hF0;
   localparam logic [7:0]  LEAD4_HI   = 8'hF4;
   localparam logic [20:0] CP_MIN2    = 21'h80;
   localparam logic [20:0] CP_MIN3    = 21'h800;
   localparam logic [20:0] CP_MIN4    = 21'h10000;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;
   localparam logic [20:0] SURR_LO    = 21'hD800;
   localparam logic [20:0] SURR_HI    = 21'hDFFF;
   localparam int          ARG_SAT    = 9;

   // VT parameter values for ESC [ n ~
   localparam logic [3:0] VT_HOME     = 4'd1;
   localparam logic [3:0] VT_END      = 4'd4;
   localparam logic [3:0] VT_PGUP     = 4'd5;
   localparam logic [3:0] VT_PGDN     = 4'd6;
   localparam logic [3:0] VT_HOME_ALT = 4'd7;
   localparam logic [3:0] VT_END_ALT  = 4'd8;

   // predictor state
   seq_state_type   esc_phase = SEQ_NORMAL;
   param_stage_type arg_stage = PS_SKIP;
   logic [3:0]      arg_mag = '0;
   logic            arg_minus = 1'b0;
   logic            arg_seen = 1'b0;
   logic [1:0]      cont_left = '0;
   logic [2:0]      cont_total = '0;
   logic [20:0]     cp_bits = '0;
   logic            cont_bad = 1'b0;

   rsp_type key_event_queue [$];
   rsp_type next_event;
   rsp_type want_event;
   bit      has_key;

   function automatic void clear_args();
      arg_stage = PS_SKIP;
      arg_mag   = '0;
      arg_minus = 1'b0;
      arg_seen  = 1'b0;
   endfunction

   function automatic void clear_utf8_build();
      cont_left  = '0;
      cont_total = '0;
      cp_bits    = '0;
      cont_bad   = 1'b0;
   endfunction

   function automatic key_kind_type letter_key(input logic [7:0] c);
      case (c)
         CH_UPPER_A: return KK_UP;
         CH_UPPER_B: return KK_DOWN;
         CH_UPPER_C: return KK_RIGHT;
         CH_UPPER_D: return KK_LEFT;
         CH_UPPER_H: return KK_HOME;
         CH_UPPER_F: return KK_END;
         default:    return KK_UNKNOWN;
      endcase
   endfunction

   // one byte or tick through the decode model; at most one key event out
   task automatic decode_key_event(input logic tick, input logic [7:0] b,
                                   output bit found, output rsp_type ev);
      key_kind_type kind;
      logic [20:0]  cp;
      logic         bad_seq;
      int           acc;
      found = 1'b1;
      kind  = KK_UNKNOWN;
      cp    = '0;
      if (tick) begin
         // flush whatever is pending
         if (esc_phase != SEQ_NORMAL) begin
            esc_phase = SEQ_NORMAL;
            clear_args();
            kind = KK_ESC;
         end else if (cont_left != 0) begin
            clear_utf8_build();
            kind = KK_UNKNOWN;
         end else begin
            found = 1'b0;
         end
      end else if (cont_left != 0) begin
         // any byte counts as a continuation inside UTF-8
         if (b[7:6] != 2'b10)
            cont_bad = 1'b1;
         cp_bits   = {cp_bits[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 0) begin
            bad_seq = cont_bad;
            if (cont_total == 3'd2 && cp_bits < CP_MIN2)
               bad_seq = 1'b1;
            if (cont_total == 3'd3 &&
                (cp_bits < CP_MIN3 || (cp_bits >= SURR_LO && cp_bits <= SURR_HI)))
               bad_seq = 1'b1;
            if (cont_total == 3'd4 && (cp_bits < CP_MIN4 || cp_bits > CP_MAX))
               bad_seq = 1'b1;
            cp = cp_bits;
            clear_utf8_build();
            kind = bad_seq ? KK_UNKNOWN : KK_CHAR;
         end else begin
            found = 1'b0;
         end
      end else begin
         case (esc_phase)
            SEQ_ESC: begin
               esc_phase = SEQ_NORMAL;
               if (b == CH_LBRACK) begin
                  esc_phase = SEQ_CSI;
                  clear_args();
                  found = 1'b0;
               end else if (b == CH_UPPER_O) begin
                  esc_phase = SEQ_SS3;
                  clear_args();
                  found = 1'b0;
               end else begin
                  // the byte after a lone ESC is dropped
                  kind = KK_ESC;
               end
            end
            SEQ_CSI: begin
               if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
                  if (b == CH_TILDE) begin
                     if (arg_seen && arg_minus) begin
                        kind = KK_UNKNOWN;
                     end else begin
                        // empty parameter reads as 1
                        case (arg_seen ? arg_mag : VT_HOME)
                           VT_HOME, VT_HOME_ALT: kind = KK_HOME;
                           VT_END, VT_END_ALT:   kind = KK_END;
                           VT_PGUP:              kind = KK_PGUP;
                           VT_PGDN:              kind = KK_PGDN;
                           default:              kind = KK_UNKNOWN;
                        endcase
                     end
                  end else begin
                     kind = letter_key(b);
                  end
                  esc_phase = SEQ_NORMAL;
                  clear_args();
               end else begin
                  // first parameter, atoi style
                  found = 1'b0;
                  if (arg_stage != PS_DONE) begin
                     if (b == CH_SEMI) begin
                        arg_stage = PS_DONE;
                     end else begin
                        arg_seen = 1'b1;
                        if (arg_stage == PS_SKIP && b == CH_PLUS) begin
                           arg_stage = PS_SIGN;
                        end else if (arg_stage == PS_SKIP && b == CH_MINUS) begin
                           arg_minus = 1'b1;
                           arg_stage = PS_SIGN;
                        end else if (b >= CH_ZERO && b <= CH_NINE) begin
                           acc       = int'(arg_mag) * 10 + int'(b - CH_ZERO);
                           arg_mag   = (acc > ARG_SAT) ? 4'(ARG_SAT) : 4'(acc);
                           arg_stage = PS_DIGITS;
                        end else if (!(arg_stage == PS_SKIP &&
                                       (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)))) begin
                           arg_stage = PS_DONE;
                        end
                     end
                  end
               end
            end
            SEQ_SS3: begin
               esc_phase = SEQ_NORMAL;
               kind = (b >= CH_FINAL_LO && b <= CH_FINAL_HI) ? letter_key(b) : KK_UNKNOWN;
            end
            default: begin
               // plain byte
               if (b == CH_ESC) begin
                  esc_phase = SEQ_ESC;
                  found = 1'b0;
               end else if (b == CH_CR || b == CH_LF) begin
                  kind = KK_ENTER;
               end else if (b == CH_DEL || b == CH_BS) begin
                  kind = KK_BACKSPACE;
               end else if (b == CH_ETX) begin
                  kind = KK_CTRLC;
               end else if (b == CH_SPACE) begin
                  kind = KK_SPACE;
               end else if (b < CH_SPACE) begin
                  kind = KK_UNKNOWN;
               end else if (b < ASCII_END) begin
                  kind = KK_CHAR;
                  cp   = {13'd0, b};
               end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                  cont_total = 3'd2;
                  cont_left  = 2'd1;
                  cp_bits    = {16'd0, b[4:0]};
                  cont_bad   = 1'b0;
                  found      = 1'b0;
               end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                  cont_total = 3'd3;
                  cont_left  = 2'd2;
                  cp_bits    = {17'd0, b[3:0]};
                  cont_bad   = 1'b0;
                  found      = 1'b0;
               end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                  cont_total = 3'd4;
                  cont_left  = 2'd3;
                  cp_bits    = {18'd0, b[2:0]};
                  cont_bad   = 1'b0;
                  found      = 1'b0;
               end else begin
                  kind = KK_UNKNOWN;
               end
            end
         endcase
      end
      ev.key_kind   = kind;
      ev.code_point = (kind == KK_CHAR) ? cp : '0;
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // compare popped key events, then predict for the accepted input
   always @(posedge clock) begin
      if (reset) begin
         esc_phase = SEQ_NORMAL;
         clear_args();
         clear_utf8_build();
         key_event_queue.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (key_event_queue.size() == 0) begin
               report_mismatch($sformatf("key event kind %0d code point 0x%0h not expected",
                                         rsp_key_kind, rsp_code_point));
            end else begin
               want_event = key_event_queue.pop_front();
               if (rsp_key_kind !== want_event.key_kind)
                  report_mismatch($sformatf("key_kind %0d, expected %0d",
                                            rsp_key_kind, want_event.key_kind));
               if (rsp_code_point !== want_event.code_point)
                  report_mismatch($sformatf("code_point 0x%0h, expected 0x%0h",
                                            rsp_code_point, want_event.code_point));
            end
         end
         if (req_push && !req_full) begin
            decode_key_event(req_mode, req_byte_value, has_key, next_event);
            if (has_key)
               key_event_queue.insert(key_event_queue.size(), next_event);
         end
         pending_count <= key_event_queue.size();
      end
   end

endmodule

[tb/sv/tb_terminal_key_sequence_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_key_sequence_decoder: stimulus and verdict for the key decoder
// Drives a directed byte stream covering control keys, escape sequences and
// UTF-8 corner cases, then random well-formed and broken sequences with random
// idle and stall bursts on both queue ports. The checker scores the results.
// ----------------------------------------------------------------------------
module tb_terminal_key_sequence_decoder;
   import tksd_pkg::*;

   localparam int         BYTE_TARGET = 800;
   localparam int         QUIET_FROM  = 680;
   localparam int         TAIL_CYCLES = 8;
   localparam int         LIMIT_NS    = 2_000_000;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LOWER_X  = 8'h78;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_mode = 1'b0;
   logic [7:0]  req_byte_value = '0;
   logic        rsp_pop = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [3:0]  rsp_key_kind;
   logic [20:0] rsp_code_point;
   int          fail_count;
   int          pending_count;

   int gap_pct = 0;
   bit tail_quiet = 1'b0;
   int bytes_sent = 0;

   terminal_key_sequence_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_key_kind   (rsp_key_kind),
      .rsp_code_point (rsp_code_point)
   );

   tksd_key_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_key_kind   (rsp_key_kind),
      .rsp_code_point (rsp_code_point),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 5))
         0:       return CH_UPPER_A;
         1:       return CH_UPPER_B;
         2:       return CH_UPPER_C;
         3:       return CH_UPPER_D;
         4:       return CH_UPPER_H;
         default: return CH_UPPER_F;
      endcase
   endfunction

   // one input transfer, with an optional idle burst ahead of it
   task automatic send_item(input logic tick, input logic [7:0] value);
      if (!tail_quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_mode       <= tick;
      req_byte_value <= tick ? 8'($urandom_range(0, 255)) : value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!tick)
         bytes_sent++;
   endtask

   // UTF-8 encoding of cp in len bytes; optionally one bad continuation or cut short
   task automatic send_utf8(input logic [20:0] cp, input int len,
                            input bit corrupt, input bit cut);
      logic [7:0] seq_bytes [4];
      int         count;
      case (len)
         2: begin
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {2'b10, cp[11:6]};
            seq_bytes[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {2'b10, cp[17:12]};
            seq_bytes[2] = {2'b10, cp[11:6]};
            seq_bytes[3] = {2'b10, cp[5:0]};
         end
      endcase
      if (corrupt)
         seq_bytes[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      count = cut ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < count; i++)
         send_item(1'b0, seq_bytes[i]);
      // a cut sequence either times out or swallows whatever follows
      if (cut && $urandom_range(0, 1))
         send_item(1'b1, '0);
   endtask

   // one random token: mostly well-formed sequences, some noise and breakage
   task automatic send_random_token();
      int         sel;
      int         len;
      logic [7:0] v;
      logic [20:0] cp;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (sel < 27) begin
         case ($urandom_range(0, 3))
            0:       v = 8'($urandom_range(0, 8'h1F));
            1:       v = CH_DEL;
            2:       v = CH_SPACE;
            default: v = 8'($urandom_range(8'h21, 8'h7E));
         endcase
         send_item(1'b0, v);
      end else if (sel < 47) begin
         // CSI with a random first parameter
         send_item(1'b0, CH_ESC);
         send_item(1'b0, CH_LBRACK);
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 7))
               0, 1, 2: v = CH_ZERO + 8'($urandom_range(0, 9));
               3:       v = $urandom_range(0, 1) ? CH_SPACE
                                                 : 8'($urandom_range(CH_TAB, CH_CR));
               4:       v = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
               5:       v = CH_SEMI;
               6:       v = 8'($urandom_range(0, 8'h3F));
               default: v = 8'($urandom_range(8'h7F, 8'hFF));
            endcase
            send_item(1'b0, v);
         end
         sel = $urandom_range(0, 99);
         if (sel < 5)
            send_item(1'b1, '0);
         else if (sel < 55)
            send_item(1'b0, CH_TILDE);
         else if (sel < 85)
            send_item(1'b0, pick_letter());
         else
            send_item(1'b0, 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end else if (sel < 57) begin
         // SS3
         send_item(1'b0, CH_ESC);
         send_item(1'b0, CH_UPPER_O);
         sel = $urandom_range(0, 99);
         if (sel < 5)
            send_item(1'b1, '0);
         else if (sel < 70)
            send_item(1'b0, pick_letter());
         else if (sel < 85)
            send_item(1'b0, 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
         else
            send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (sel < 62) begin
         // lone ESC
         send_item(1'b0, CH_ESC);
         if ($urandom_range(0, 2) == 0)
            send_item(1'b1, '0);
         else
            send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (sel < 82) begin
         // UTF-8 of in-range code points, surrogates included
         len = $urandom_range(2, 4);
         case (len)
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3: cp = 21'($urandom_range(21'h800, 21'hFFFF));
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
         endcase
         send_utf8(cp, len, 1'b0, 1'b0);
      end else if (sel < 93) begin
         // overlong, surrogate, out of range, bad continuation or cut short
         len = $urandom_range(2, 4);
         case (len)
            2: cp = 21'($urandom_range(0, 21'h7FF));
            3: cp = 21'($urandom_range(0, 21'hFFFF));
            default: cp = 21'($urandom_range(0, 21'h13FFFF));
         endcase
         send_utf8(cp, len, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
      end else begin
         send_item(1'b1, '0);
      end
   endtask

   // result side: pop with random stall bursts
   initial begin : pop_driver
      int stall_left;
      int stall_pct;
      int window;
      stall_left = 0;
      stall_pct  = 0;
      window     = 0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            window    = 64;
            stall_pct = pick_idle_pct();
         end
         window--;
         if (stall_left == 0 && !tail_quiet && stall_pct != 0 &&
             $urandom_range(1, 100) <= stall_pct)
            stall_left = $urandom_range(1, 6);
         if (stall_left != 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // stimulus and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, byte extremes, control keys
      send_item(1'b1, '0);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, CH_CR);
      send_item(1'b0, CH_DEL);
      send_item(1'b0, CH_SPACE);
      // empty parameter reads as Home
      send_item(1'b0, CH_ESC);
      send_item(1'b0, CH_LBRACK);
      send_item(1'b0, CH_TILDE);
      // saturated parameter
      send_item(1'b0, CH_ESC);
      send_item(1'b0, CH_LBRACK);
      send_item(1'b0, CH_NINE);
      send_item(1'b0, CH_NINE);
      send_item(1'b0, CH_TILDE);
      // negative parameter
      send_item(1'b0, CH_ESC);
      send_item(1'b0, CH_LBRACK);
      send_item(1'b0, CH_MINUS);
      send_item(1'b0, CH_ZERO + 8'd5);
      send_item(1'b0, CH_TILDE);
      // ESC then an ordinary byte, SS3 with a non-final byte
      send_item(1'b0, CH_ESC);
      send_item(1'b0, CH_LOWER_X);
      send_item(1'b0, CH_ESC);
      send_item(1'b0, CH_UPPER_O);
      send_item(1'b0, CH_SPACE);
      // highest code point, then ESC taken as a continuation byte
      send_utf8(21'h10FFFF, 4, 1'b0, 1'b0);
      send_item(1'b0, 8'hE2);
      send_item(1'b0, CH_ESC);
      send_item(1'b0, 8'h82);

      // random part
      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 15) == 0)
            gap_pct = pick_idle_pct();
         if (bytes_sent >= QUIET_FROM)
            tail_quiet = 1'b1;
         send_random_token();
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("terminal_key_sequence_decoder test passed");
      else
         $display("terminal_key_sequence_decoder test failed");
      $finish;
   end

   // watchdog
   initial begin
      #LIMIT_NS;
      $display("terminal_key_sequence_decoder test failed");
      $finish;
   end

endmodule

[files.f]
rtl/tksd_pkg.sv
rtl/tksd_fifo.sv
rtl/tksd_front.sv
rtl/tksd_back.sv
rtl/terminal_key_sequence_decoder.sv
tb/sv/tksd_key_event_checker.sv
tb/sv/tb_terminal_key_sequence_decoder.sv
